FILE: hdl/tci_pkg.sv
// Shared constants and register codes for the trilinear cell interpolator.
package tci_pkg;

  localparam int INDEX_WIDTH    = 6;
  localparam int OFFSET_WIDTH   = 18;
  localparam int CFG_DATA_WIDTH = 7;
  localparam int CFG_ADDR_WIDTH = 2;
  localparam int CORNER_COUNT   = 8;
  localparam int AXIS_COUNT     = 3;
  localparam int BITS_PER_STAGE = 4;
  localparam int BACK_STAGES    = 6;

  localparam int RESET_XZ_SIZE = 4;
  localparam int RESET_Y_SIZE  = 8;

  // Axis lanes in the fraction unit
  localparam int AXIS_Y = 0;
  localparam int AXIS_X = 1;
  localparam int AXIS_Z = 2;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_XZ_SIZE = 2'd0,
    REG_Y_SIZE  = 2'd1
  } cfg_reg_t;

endpackage

FILE: hdl/tci_front.sv
// Front end: fraction divider pipeline and flat offset computation.
module tci_front #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_WIDTH  = 16,
  parameter int SIZE_W      = 7,
  parameter int ITEM_W      = 8 * 32 + 3 * 16 + 18
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_fire,
  input  logic [tci_pkg::CORNER_COUNT*VALUE_WIDTH-1:0]       corners,
  input  logic [tci_pkg::INDEX_WIDTH-1:0]                    y_index,
  input  logic [tci_pkg::INDEX_WIDTH-1:0]                    x_index,
  input  logic [tci_pkg::INDEX_WIDTH-1:0]                    z_index,
  input  logic [SIZE_W-1:0]                                  xz_size,
  input  logic [SIZE_W-1:0]                                  y_size,
  input  logic [2*SIZE_W-1:0]                                cell_area,
  output logic                                               item_valid,
  output logic [ITEM_W-1:0]                                  item_data
);

  localparam int DS     = (FRAC_WIDTH + tci_pkg::BITS_PER_STAGE - 1) / tci_pkg::BITS_PER_STAGE;
  localparam int CW     = tci_pkg::CORNER_COUNT * VALUE_WIDTH;
  localparam int CMP_W  = ((SIZE_W > tci_pkg::INDEX_WIDTH) ? SIZE_W : tci_pkg::INDEX_WIDTH) + 1;
  localparam int OFF_RW = tci_pkg::INDEX_WIDTH + 2 * SIZE_W + 2;
  localparam int OFF_W  = (OFF_RW > tci_pkg::OFFSET_WIDTH) ? OFF_RW : tci_pkg::OFFSET_WIDTH;

  logic [DS-1:0]                        vld_r;
  logic [SIZE_W-1:0]                    rem_r   [DS][tci_pkg::AXIS_COUNT];
  logic [FRAC_WIDTH-1:0]                quo_r   [DS][tci_pkg::AXIS_COUNT];
  logic [SIZE_W-1:0]                    rem_nxt [DS][tci_pkg::AXIS_COUNT];
  logic [FRAC_WIDTH-1:0]                quo_nxt [DS][tci_pkg::AXIS_COUNT];
  logic [tci_pkg::AXIS_COUNT-1:0]       sat_r   [DS];
  logic [CW-1:0]                        crn_r   [DS];
  logic [tci_pkg::OFFSET_WIDTH-1:0]     off_r   [DS];

  logic [tci_pkg::INDEX_WIDTH-1:0]      idx  [tci_pkg::AXIS_COUNT];
  logic [SIZE_W-1:0]                    size [tci_pkg::AXIS_COUNT];
  logic [tci_pkg::AXIS_COUNT-1:0]       sat_in;
  logic [OFF_W-1:0]                     off_full;

  assign idx[tci_pkg::AXIS_Y]  = y_index;
  assign idx[tci_pkg::AXIS_X]  = x_index;
  assign idx[tci_pkg::AXIS_Z]  = z_index;
  assign size[tci_pkg::AXIS_Y] = y_size;
  assign size[tci_pkg::AXIS_X] = xz_size;
  assign size[tci_pkg::AXIS_Z] = xz_size;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [SIZE_W:0] div_step(input logic [SIZE_W-1:0] rem,
                                               input logic [SIZE_W-1:0] dsr);
    logic [SIZE_W:0] sh;
    logic            ge;
    logic [SIZE_W:0] nr;
    sh = {rem, 1'b0};
    ge = (sh >= {1'b0, dsr});
    nr = ge ? (sh - {1'b0, dsr}) : sh;
    return {ge, nr[SIZE_W-1:0]};
  endfunction

  always_comb begin
    for (int l = 0; l < tci_pkg::AXIS_COUNT; l++) begin
      sat_in[l] = (CMP_W'(idx[l]) >= CMP_W'(size[l]));
    end
    off_full = OFF_W'(y_index) * OFF_W'(cell_area) + OFF_W'(x_index) * OFF_W'(xz_size)
             + OFF_W'(z_index);
  end

  for (genvar s = 0; s < DS; s++) begin : g_stage
    always_comb begin
      logic [SIZE_W-1:0]     r;
      logic [FRAC_WIDTH-1:0] q;
      logic [SIZE_W:0]       st;
      for (int l = 0; l < tci_pkg::AXIS_COUNT; l++) begin
        if (s == 0) begin
          r = SIZE_W'(idx[l]);
          q = '0;
        end else begin
          r = rem_r[(s == 0) ? 0 : s-1][l];
          q = quo_r[(s == 0) ? 0 : s-1][l];
        end
        for (int j = 0; j < tci_pkg::BITS_PER_STAGE; j++) begin
          if (s * tci_pkg::BITS_PER_STAGE + j < FRAC_WIDTH) begin
            st = div_step(r, size[l]);
            r  = st[SIZE_W-1:0];
            q  = {q[FRAC_WIDTH-2:0], st[SIZE_W]};
          end
        end
        rem_nxt[s][l] = r;
        quo_nxt[s][l] = q;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= (s == 0) ? in_fire : vld_r[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < tci_pkg::AXIS_COUNT; l++) begin
        rem_r[s][l] <= rem_nxt[s][l];
        quo_r[s][l] <= quo_nxt[s][l];
      end
      if (s == 0) begin
        sat_r[s] <= sat_in;
        crn_r[s] <= corners;
        off_r[s] <= off_full[tci_pkg::OFFSET_WIDTH-1:0];
      end else begin
        sat_r[s] <= sat_r[(s == 0) ? 0 : s-1];
        crn_r[s] <= crn_r[(s == 0) ? 0 : s-1];
        off_r[s] <= off_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  // An index at or past the cell size saturates just below one
  logic [FRAC_WIDTH-1:0] frac [tci_pkg::AXIS_COUNT];
  always_comb begin
    for (int l = 0; l < tci_pkg::AXIS_COUNT; l++) begin
      frac[l] = sat_r[DS-1][l] ? {FRAC_WIDTH{1'b1}} : quo_r[DS-1][l];
    end
  end

  assign item_valid = vld_r[DS-1];
  assign item_data  = {off_r[DS-1], frac[tci_pkg::AXIS_Z], frac[tci_pkg::AXIS_X],
                       frac[tci_pkg::AXIS_Y], crn_r[DS-1]};

endmodule

FILE: hdl/tci_queue.sv
// Short queue between the fraction front end and the blend back end.
module tci_queue #(
  parameter int W     = 64,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               push_data,
  input  logic                       pop,
  output logic                       pop_valid,
  output logic [W-1:0]               pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (cnt_r < CW'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue read while empty");

endmodule

FILE: hdl/tci_back.sv
// Back end: three levels of blends (y, x, z), each a multiply stage and an add stage.
module tci_back #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_WIDTH  = 16,
  parameter int ITEM_W      = 8 * 32 + 3 * 16 + 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  logic [ITEM_W-1:0]                 q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [VALUE_WIDTH-1:0]            out_value,
  output logic [tci_pkg::OFFSET_WIDTH-1:0]  out_offset
);

  localparam int VW = VALUE_WIDTH;
  localparam int F  = FRAC_WIDTH;
  localparam int PW = VW + F + 2;
  localparam int CB = tci_pkg::CORNER_COUNT * VW;
  localparam int OW = tci_pkg::OFFSET_WIDTH;

  // (b - a) * f, exact
  function automatic logic signed [PW-1:0] blend_mul(input logic [VW-1:0] a,
                                                     input logic [VW-1:0] b,
                                                     input logic [F-1:0]  f);
    logic signed [VW:0]   d;
    logic signed [PW-1:0] de;
    logic signed [PW-1:0] fe;
    d  = $signed({b[VW-1], b}) - $signed({a[VW-1], a});
    de = PW'(d);
    fe = PW'($signed({1'b0, f}));
    return de * fe;
  endfunction

  // a + floor(p / 2^F); a convex blend always fits the value width
  function automatic logic [VW-1:0] blend_add(input logic [VW-1:0]        a,
                                              input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    logic [VW+1:0]        s;
    sh = p >>> F;
    s  = {{2{a[VW-1]}}, a} + sh[VW+1:0];
    return s[VW-1:0];
  endfunction

  logic [VW-1:0] c [tci_pkg::CORNER_COUNT];
  logic [F-1:0]  fy, fx, fz;
  logic [OW-1:0] off;
  logic          en;

  always_comb begin
    for (int i = 0; i < tci_pkg::CORNER_COUNT; i++) begin
      c[i] = q_data[i*VW +: VW];
    end
  end
  assign fy  = q_data[CB +: F];
  assign fx  = q_data[CB + F +: F];
  assign fz  = q_data[CB + 2*F +: F];
  assign off = q_data[CB + 3*F +: OW];

  // Whole back end advances together; hold while the result is not taken
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  logic [tci_pkg::BACK_STAGES-1:0] vld_r;

  logic [VW-1:0]        a1_r [4];
  logic signed [PW-1:0] p1_r [4];
  logic [F-1:0]         fx1_r, fz1_r;
  logic [OW-1:0]        off1_r;

  logic [VW-1:0]        v1_r [4];
  logic [F-1:0]         fx2_r, fz2_r;
  logic [OW-1:0]        off2_r;

  logic [VW-1:0]        a2_r [2];
  logic signed [PW-1:0] p2_r [2];
  logic [F-1:0]         fz3_r;
  logic [OW-1:0]        off3_r;

  logic [VW-1:0]        z_r [2];
  logic [F-1:0]         fz4_r;
  logic [OW-1:0]        off4_r;

  logic [VW-1:0]        a3_r;
  logic signed [PW-1:0] p3_r;
  logic [OW-1:0]        off5_r;

  logic [VW-1:0]        val_r;
  logic [OW-1:0]        off6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[tci_pkg::BACK_STAGES-2:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // y blends pair corner i with corner i+2 (i = 0, 1, 4, 5) in each z plane
      for (int k = 0; k < 4; k++) begin
        a1_r[k] <= c[(k < 2) ? k : k + 2];
        p1_r[k] <= blend_mul(c[(k < 2) ? k : k + 2], c[(k < 2) ? k + 2 : k + 4], fy);
      end
      fx1_r  <= fx;
      fz1_r  <= fz;
      off1_r <= off;

      for (int k = 0; k < 4; k++) begin
        v1_r[k] <= blend_add(a1_r[k], p1_r[k]);
      end
      fx2_r  <= fx1_r;
      fz2_r  <= fz1_r;
      off2_r <= off1_r;

      for (int k = 0; k < 2; k++) begin
        a2_r[k] <= v1_r[2*k];
        p2_r[k] <= blend_mul(v1_r[2*k], v1_r[2*k+1], fx2_r);
      end
      fz3_r  <= fz2_r;
      off3_r <= off2_r;

      for (int k = 0; k < 2; k++) begin
        z_r[k] <= blend_add(a2_r[k], p2_r[k]);
      end
      fz4_r  <= fz3_r;
      off4_r <= off3_r;

      a3_r   <= z_r[0];
      p3_r   <= blend_mul(z_r[0], z_r[1], fz4_r);
      off5_r <= off4_r;

      val_r  <= blend_add(a3_r, p3_r);
      off6_r <= off5_r;
    end
  end

  assign out_valid  = vld_r[tci_pkg::BACK_STAGES-1];
  assign out_value  = val_r;
  assign out_offset = off6_r;

endmodule

FILE: hdl/trilinear_cell_interpolator.sv
// Trilinear cell interpolator top level: configuration registers, front end, queue, back end.
//
// Takes one grid point per cycle and returns one interpolated value with its flat offset
// per cycle, in order, while the output is not stalled. The fraction divider resolves four
// quotient bits per stage, then the point passes through the queue, then three blend levels
// of a multiply and an add stage each. Input items are taken while the queue has room for
// every point already accepted and not yet drained, so a stalled output fills the queue and
// then holds in_tready low. Cell sizes are clamped to 1..MAX_CELL_SIZE on write; write them
// only while no item is in flight.
module trilinear_cell_interpolator #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRAC_WIDTH    = 16,
  parameter int MAX_CELL_SIZE = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata, low bit up: corner_000, corner_100, corner_010, corner_110, corner_001,
  // corner_101, corner_011, corner_111, y_index, x_index, z_index, zero pad
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((8*VALUE_WIDTH+18+7)/8)*8-1:0]  in_tdata,
  // out_tdata, low bit up: value, offset, zero pad
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((VALUE_WIDTH+18+7)/8)*8-1:0]    out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tci_pkg::CFG_ADDR_WIDTH-1:0]     cfg_index,
  input  logic [tci_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  localparam int IW     = tci_pkg::INDEX_WIDTH;
  localparam int OW     = tci_pkg::OFFSET_WIDTH;
  localparam int CB     = tci_pkg::CORNER_COUNT * VALUE_WIDTH;
  localparam int OUT_W  = ((VALUE_WIDTH + OW + 7) / 8) * 8;
  localparam int SIZE_W = $clog2(MAX_CELL_SIZE + 1);
  localparam int CL_W   = ((SIZE_W > tci_pkg::CFG_DATA_WIDTH) ? SIZE_W
                                                              : tci_pkg::CFG_DATA_WIDTH) + 1;
  localparam int ITEM_W = CB + 3 * FRAC_WIDTH + OW;
  localparam int DS     = (FRAC_WIDTH + tci_pkg::BITS_PER_STAGE - 1) / tci_pkg::BITS_PER_STAGE;
  localparam int QD     = DS + 3;
  localparam int QC_W   = $clog2(QD + 1);
  localparam int RST_W  = (tci_pkg::RESET_XZ_SIZE > MAX_CELL_SIZE) ? MAX_CELL_SIZE
                                                                   : tci_pkg::RESET_XZ_SIZE;
  localparam int RST_H  = (tci_pkg::RESET_Y_SIZE > MAX_CELL_SIZE) ? MAX_CELL_SIZE
                                                                  : tci_pkg::RESET_Y_SIZE;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [tci_pkg::CFG_DATA_WIDTH-1:0] v);
    logic [CL_W-1:0] e;
    e = CL_W'(v);
    if (e == '0) begin
      return SIZE_W'(1);
    end else if (e > CL_W'(MAX_CELL_SIZE)) begin
      return SIZE_W'(MAX_CELL_SIZE);
    end
    return e[SIZE_W-1:0];
  endfunction

  // Configuration registers; the squared width feeds the offset multiply
  logic [SIZE_W-1:0]   xz_size_r, xz_size_nxt;
  logic [SIZE_W-1:0]   y_size_r, y_size_nxt;
  logic [2*SIZE_W-1:0] cell_area_r, cell_area_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    xz_size_nxt   = xz_size_r;
    y_size_nxt    = y_size_r;
    cell_area_nxt = cell_area_r;
    if (cfg_valid) begin
      case (tci_pkg::cfg_reg_t'(cfg_index))
        tci_pkg::REG_XZ_SIZE: begin
          xz_size_nxt   = clamp_size(cfg_data);
          cell_area_nxt = (2*SIZE_W)'(xz_size_nxt) * (2*SIZE_W)'(xz_size_nxt);
        end
        tci_pkg::REG_Y_SIZE: begin
          y_size_nxt = clamp_size(cfg_data);
        end
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xz_size_r   <= SIZE_W'(RST_W);
      y_size_r    <= SIZE_W'(RST_H);
      cell_area_r <= (2*SIZE_W)'(RST_W * RST_W);
    end else begin
      xz_size_r   <= xz_size_nxt;
      y_size_r    <= y_size_nxt;
      cell_area_r <= cell_area_nxt;
    end
  end

  // Items accepted and not yet pulled from the queue
  logic [QC_W-1:0] credit_r, credit_nxt;
  logic            in_fire;
  logic            q_pop;
  logic            f_valid;
  logic [ITEM_W-1:0] f_data;
  logic            q_valid;
  logic [ITEM_W-1:0] q_data;
  logic [QC_W-1:0] q_count;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [OW-1:0]   res_offset;

  assign in_tready  = (credit_r < QC_W'(QD));
  assign in_fire    = in_tvalid && in_tready;
  assign credit_nxt = credit_r + QC_W'(in_fire) - QC_W'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  tci_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_WIDTH  (FRAC_WIDTH),
    .SIZE_W      (SIZE_W),
    .ITEM_W      (ITEM_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .corners     (in_tdata[CB-1:0]),
    .y_index     (in_tdata[CB +: IW]),
    .x_index     (in_tdata[CB + IW +: IW]),
    .z_index     (in_tdata[CB + 2*IW +: IW]),
    .xz_size     (xz_size_r),
    .y_size      (y_size_r),
    .cell_area   (cell_area_r),
    .item_valid  (f_valid),
    .item_data   (f_data)
  );

  tci_queue #(
    .W     (ITEM_W),
    .DEPTH (QD)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data (f_data),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .count     (q_count)
  );

  tci_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_WIDTH  (FRAC_WIDTH),
    .ITEM_W      (ITEM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (res_value),
    .out_offset (res_offset)
  );

  assign out_tdata = OUT_W'({res_offset, res_value});

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= QC_W'(QD))
    else $error("more items in flight than the queue can hold");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= credit_r)
    else $error("queue holds an item that was never accepted");

endmodule
